/* hw/rtl/bdq_pkg.sv */
package bdq_pkg;

	localparam int OP_W   = 4;
	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 6;
	localparam int STS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_REPLACE    = 4'd4,
		OP_SEARCH     = 4'd5,
		OP_COUNT      = 4'd6,
		OP_LIST       = 4'd7,
		OP_CLEAR      = 4'd8
	} bdq_op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK      = 2'd0,
		STS_EMPTY   = 2'd1,
		STS_FULL    = 2'd2,
		STS_BAD_POS = 2'd3
	} bdq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_SRCH_FIN,
		S_SRCH_OUT,
		S_LIST_RD,
		S_LIST_OUT
	} bdq_state_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_PUSH_FRONT,
		UPD_PUSH_BACK,
		UPD_POP_FRONT,
		UPD_POP_BACK,
		UPD_REPLACE,
		UPD_CLEAR
	} bdq_upd_t;

	typedef struct packed {
		logic        load;
		logic        rd_en;
		logic        idx_inc;
		logic        cmp_en;
		bdq_upd_t    upd;
		logic        out_load;
		logic        out_elem;
		logic        out_found;
		bdq_status_t out_status;
		logic        out_last;
	} bdq_cmd_t;

	typedef struct packed {
		bdq_op_t op;
		logic    empty;
		logic    full;
		logic    pos_bad;
		logic    scan_last;
		logic    list_end;
		logic    out_free;
	} bdq_sts_t;

endpackage

/* hw/rtl/bdq_req_if.sv */
interface bdq_req_if;
	import bdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, operation, value, position, input ready);
	modport sink (input valid, operation, value, position, output ready);

endinterface

/* hw/rtl/bdq_rsp_if.sv */
interface bdq_rsp_if;
	import bdq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element;
	logic                     found;
	logic [LEN_W-1:0]         length;
	logic [STS_W-1:0]         status;
	logic                     last;

	modport source (output valid, element, found, length, status, last, input ready);
	modport sink (input valid, element, found, length, status, last, output ready);

endinterface

/* hw/rtl/bdq_ram.sv */
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/bdq_ctrl.sv */
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bdq_pkg::bdq_sts_t sts,
	output bdq_pkg::bdq_cmd_t cmd
);
	import bdq_pkg::*;

	bdq_state_t  state_q;
	bdq_state_t  state_d;
	bdq_status_t ex_sts;
	bdq_upd_t    ex_upd;
	logic        ex_walk;
	bdq_state_t  ex_walk_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.upd        = UPD_NONE;
		cmd.out_status = STS_OK;
		ex_sts         = STS_OK;
		ex_upd         = UPD_NONE;
		ex_walk        = 1'b0;
		ex_walk_state  = S_IDLE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.op)
					OP_PUSH_FRONT: begin
						if (sts.full) ex_sts = STS_FULL;
						else ex_upd = UPD_PUSH_FRONT;
					end
					OP_PUSH_BACK: begin
						if (sts.full) ex_sts = STS_FULL;
						else ex_upd = UPD_PUSH_BACK;
					end
					OP_POP_FRONT: begin
						if (sts.empty) ex_sts = STS_EMPTY;
						else ex_upd = UPD_POP_FRONT;
					end
					OP_POP_BACK: begin
						if (sts.empty) ex_sts = STS_EMPTY;
						else ex_upd = UPD_POP_BACK;
					end
					OP_REPLACE: begin
						if (sts.empty) ex_sts = STS_EMPTY;
						else if (sts.pos_bad) ex_sts = STS_BAD_POS;
						else ex_upd = UPD_REPLACE;
					end
					OP_SEARCH: begin
						if (sts.empty) begin
							ex_sts = STS_EMPTY;
						end else begin
							ex_walk       = 1'b1;
							ex_walk_state = S_SRCH;
						end
					end
					OP_LIST: begin
						if (sts.empty) begin
							ex_sts = STS_EMPTY;
						end else begin
							ex_walk       = 1'b1;
							ex_walk_state = S_LIST_RD;
						end
					end
					OP_CLEAR: begin
						ex_upd = UPD_CLEAR;
					end
					default: begin
					end
				endcase
				if (ex_walk) begin
					state_d = ex_walk_state;
				end else if (sts.out_free) begin
					cmd.upd        = ex_upd;
					cmd.out_load   = 1'b1;
					cmd.out_status = ex_sts;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_SRCH: begin
				cmd.rd_en   = 1'b1;
				cmd.idx_inc = 1'b1;
				cmd.cmp_en  = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SRCH_FIN;
				end
			end
			S_SRCH_FIN: begin
				cmd.cmp_en = 1'b1;
				state_d    = S_SRCH_OUT;
			end
			S_SRCH_OUT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_found = 1'b1;
					cmd.out_last  = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_LIST_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_LIST_OUT;
			end
			S_LIST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_elem = 1'b1;
					cmd.out_last = sts.list_end;
					if (sts.list_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/bdq_dp.sv */
module bdq_dp #(
	parameter int DEPTH      = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdq_pkg::bdq_cmd_t                 cmd,
	output bdq_pkg::bdq_sts_t                 sts,
	input  logic [bdq_pkg::OP_W-1:0]          in_operation,
	input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
	input  logic [bdq_pkg::POS_W-1:0]         in_position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bdq_pkg::DATA_W-1:0] out_element,
	output logic                              out_found,
	output logic [bdq_pkg::LEN_W-1:0]         out_length,
	output logic [bdq_pkg::STS_W-1:0]         out_status,
	output logic                              out_last
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int LW = (CW > LEN_W) ? CW : LEN_W;
	localparam int EW = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

	logic [OP_W-1:0]          op_q;
	logic [VALUE_BITS-1:0]    val_q;
	logic [POS_W-1:0]         pos_q;
	logic [AW-1:0]            head_q;
	logic [AW-1:0]            head_d;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic [CW-1:0]            idx_q;
	logic                     found_q;
	logic                     pend_q;
	logic                     out_vld_q;
	logic signed [DATA_W-1:0] element_q;
	logic                     found_out_q;
	logic [LEN_W-1:0]         length_q;
	logic [STS_W-1:0]         status_q;
	logic                     last_q;

	logic signed [EW-1:0]  val_sx;
	logic [CW-1:0]         pos_off;
	logic [CW-1:0]         slot_off;
	logic [CW:0]           slot_sum;
	logic [CW:0]           slot_idx;
	logic [AW-1:0]         slot_addr;
	logic [AW-1:0]         head_dec;
	logic [AW-1:0]         head_inc;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] rd_data;
	logic [EW-1:0]         elem_ext;
	logic [LW-1:0]         len_ext;
	logic                  out_free;

	assign val_sx   = EW'(in_value);
	assign pos_off  = CW'(pos_q - POS_W'(1));
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		case (cmd.upd)
			UPD_PUSH_BACK: slot_off = count_q;
			UPD_REPLACE:   slot_off = pos_off;
			default:       slot_off = idx_q;
		endcase
	end

	assign slot_sum  = (CW+1)'(head_q) + (CW+1)'(slot_off);
	assign slot_idx  = (slot_sum >= (CW+1)'(DEPTH)) ? slot_sum - (CW+1)'(DEPTH) : slot_sum;
	assign slot_addr = slot_idx[AW-1:0];

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		we      = 1'b0;
		waddr   = slot_addr;
		case (cmd.upd)
			UPD_PUSH_FRONT: begin
				head_d  = head_dec;
				count_d = count_q + CW'(1);
				we      = 1'b1;
				waddr   = head_dec;
			end
			UPD_PUSH_BACK: begin
				count_d = count_q + CW'(1);
				we      = 1'b1;
			end
			UPD_POP_FRONT: begin
				head_d  = head_inc;
				count_d = count_q - CW'(1);
			end
			UPD_POP_BACK: begin
				count_d = count_q - CW'(1);
			end
			UPD_REPLACE: begin
				we = 1'b1;
			end
			UPD_CLEAR: begin
				head_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	bdq_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (val_q),
		.re    (cmd.rd_en),
		.raddr (slot_addr),
		.rdata (rd_data)
	);

	assign out_free = !out_vld_q || out_ready;
	assign elem_ext = EW'(rd_data);
	assign len_ext  = LW'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			pend_q  <= cmd.rd_en;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.cmp_en && pend_q && (rd_data == val_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_operation;
			val_q <= val_sx[VALUE_BITS-1:0];
			pos_q <= in_position;
		end
		if (cmd.out_load) begin
			element_q   <= cmd.out_elem ? elem_ext[DATA_W-1:0] : '0;
			found_out_q <= cmd.out_found & found_q;
			length_q    <= len_ext[LEN_W-1:0];
			status_q    <= cmd.out_elem ? STS_OK : cmd.out_status;
			last_q      <= cmd.out_last;
		end
	end

	always_comb begin
		sts.op        = bdq_op_t'(op_q);
		sts.empty     = (count_q == '0);
		sts.full      = (count_q == CW'(DEPTH));
		sts.pos_bad   = (pos_q == '0) || (PW'(pos_q) > PW'(count_q));
		sts.scan_last = ((CW+1)'(idx_q) + (CW+1)'(1)) == (CW+1)'(count_q);
		sts.list_end  = (idx_q == count_q);
		sts.out_free  = out_free;
	end

	assign out_valid   = out_vld_q;
	assign out_element = element_q;
	assign out_found   = found_out_q;
	assign out_length  = length_q;
	assign out_status  = status_q;
	assign out_last    = last_q;

endmodule

/* hw/rtl/bounded_deque_with_search.sv */
// Channel  Dir  Fields                                    Transaction when
// req      in   operation[3:0] value[31:0] position[5:0]  req.valid && req.ready
// rsp      out  element[31:0] found length[5:0]           rsp.valid && rsp.ready
//               status[1:0] last
//
// One operation at a time; req.ready is high only while the controller is idle.
// Push, pop, replace, count, clear: EXEC only. Search: SRCH scan, SRCH_FIN, SRCH_OUT.
// List: LIST_RD, then one element a cycle if rsp is free; single RAM read port.
// The registered rsp stage frees req while a result waits; rsp stalls hold list walks.
// Reset (arst_n low) empties the list at once; RAM contents are not cleared.
module bounded_deque_with_search #(
	parameter int DEPTH      = 32,
	parameter int VALUE_BITS = 32
) (
	input logic              clk,
	input logic              arst_n,
	bdq_req_if.sink          req,
	bdq_rsp_if.source        rsp
);
	import bdq_pkg::*;

	bdq_cmd_t cmd;
	bdq_sts_t sts;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdq_dp #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_operation (req.operation),
		.in_value     (req.value),
		.in_position  (req.position),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_element  (rsp.element),
		.out_found    (rsp.found),
		.out_length   (rsp.length),
		.out_status   (rsp.status),
		.out_last     (rsp.last)
	);

endmodule

/* hw/rtl/bdq_chk.sv */
module bdq_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_found,
	input logic [bdq_pkg::STS_W-1:0]  out_status,
	input logic                       out_last
);
	import bdq_pkg::*;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("req accepted twice in a row");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != STS_OK) |-> out_last)
		else $error("error status on a non-final result");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_found |-> (out_status == STS_OK) && out_last)
		else $error("found flag with bad status or not final");

	a_run_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> (out_status == STS_OK) && !out_found)
		else $error("non-final result outside a clean list run");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("rsp valid dropped while stalled");

endmodule

bind bounded_deque_with_search bdq_chk u_bdq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_found  (rsp.found),
	.out_status (rsp.status),
	.out_last   (rsp.last)
);
